// ----- rtl/core/eoq_pkg.sv -----
// Shared types and constants for the elevator order queue.
// No dependencies; imported by every module of the block.
package eoq_pkg;

  // Fixed field widths of the stream words
  localparam int unsigned FLOOR_W     = 2;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned LEN_W       = 3;
  localparam int unsigned VEC_W       = 4;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 24;

  // Event code carried in tuser bit 0
  localparam logic FUNC_ARRIVE = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_UP   = 2'd0,
    KIND_DOWN = 2'd1,
    KIND_CAB  = 2'd2
  } button_kind_e;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_PRESS  = 2'd1,
    OP_ARRIVE = 2'd2
  } cmd_op_e;

  // Classified event handed from front to back
  typedef struct packed {
    cmd_op_e             op;
    logic [FLOOR_W-1:0]  floor;
    logic [KIND_W-1:0]   kind;
  } eoq_cmd_t;

  // Result word; next_floor sits in the lowest bits
  typedef struct packed {
    logic              dropped;
    logic [VEC_W-1:0]  cab_requests;
    logic [VEC_W-1:0]  down_requests;
    logic [VEC_W-1:0]  up_requests;
    logic [LEN_W-1:0]  queue_length;
    logic              queue_nonempty;
    logic [FLOOR_W-1:0] next_floor;
  } eoq_result_t;

endpackage

// ----- rtl/core/elevator_order_queue.sv -----
// Elevator order queue: the back end walks the queue slots for each item (search,
// then shift on an arrival that hits), one queue slot per cycle for search and shift.
// The result is registered in the done state once the output register is free.
// A two-word command queue lets the input side keep accepting while busy.
// Reset (rst_ni low, async) empties the queue and clears all request flags;
// queue slot contents are not reset and are only read below the fill count.
module elevator_order_queue import eoq_pkg::*; #(
  parameter int unsigned FLOOR_COUNT = 4,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Event words
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // [1:0] floor, rest zero
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser_i,  // [0] func, [2:1] button_kind
  // Result words
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o   // [1:0] next_floor, [2] queue_nonempty,
                                                  // [5:3] queue_length, [9:6] up_requests,
                                                  // [13:10] down_requests,
                                                  // [17:14] cab_requests, [18] dropped
);

  logic        cmd_valid;
  logic        cmd_ready;
  eoq_cmd_t    cmd;
  eoq_result_t res;

  // Front: classify presses and arrivals, buffer them
  eoq_front #(
    .FLOOR_COUNT (FLOOR_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .func_i      (s_axis_tuser_i[0]),
    .floor_i     (s_axis_tdata_i[FLOOR_W-1:0]),
    .kind_i      (s_axis_tuser_i[KIND_W:1]),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Back: flag update, queue search/append/remove, result register
  eoq_back #(
    .FLOOR_COUNT (FLOOR_COUNT),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  // Upper pad bits come out as zero
  assign m_axis_tdata_o = OUT_TDATA_W'(res);

  // A classified press always carries a real button kind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready && cmd.op == OP_PRESS) |->
      (cmd.kind == KIND_UP || cmd.kind == KIND_DOWN || cmd.kind == KIND_CAB))
    else $error("press command with unknown button kind");

  // An empty queue reports floor zero at the head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !res.queue_nonempty) |-> (res.next_floor == '0))
    else $error("empty queue reports a head floor");

  // A dropped floor means the queue is at full depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res.dropped) |-> (res.queue_length == LEN_W'(QUEUE_DEPTH)))
    else $error("drop reported with room left in the queue");

  // Nonempty flag agrees with the length while the length is not masked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ((QUEUE_DEPTH >= 8) || (res.queue_nonempty == (res.queue_length != '0))))
    else $error("queue_nonempty disagrees with queue_length");

endmodule

// ----- rtl/core/eoq_front.sv -----
// Front end: accepts input words, classifies them into commands and
// buffers them in a two-entry queue. Depends on eoq_pkg.
module eoq_front import eoq_pkg::*; #(
  parameter int unsigned FLOOR_COUNT = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic [FLOOR_W-1:0]    floor_i,
  input  logic [KIND_W-1:0]     kind_i,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i,
  output eoq_cmd_t              cmd_o
);

  eoq_cmd_t   cls;
  eoq_cmd_t   entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;

  // Classify: out-of-range floor, or a press with an unknown button kind, does nothing
  always_comb begin
    cls.floor = floor_i;
    cls.kind  = kind_i;
    if (32'(floor_i) >= FLOOR_COUNT) begin
      cls.op = OP_NONE;
    end else if (func_i == FUNC_ARRIVE) begin
      cls.op = OP_ARRIVE;
    end else if (kind_i == KIND_UP || kind_i == KIND_DOWN || kind_i == KIND_CAB) begin
      cls.op = OP_PRESS;
    end else begin
      cls.op = OP_NONE;
    end
  end

  assign in_ready_o  = (fill_q != 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ----- rtl/core/eoq_back.sv -----
// Back end: request flags, ordered floor queue with a slot walker,
// and the registered result word. Depends on eoq_pkg.
module eoq_back import eoq_pkg::*; #(
  parameter int unsigned FLOOR_COUNT = 4,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cmd_valid_i,
  output logic         cmd_ready_o,
  input  eoq_cmd_t     cmd_i,
  output logic         res_valid_o,
  input  logic         res_ready_i,
  output eoq_result_t  res_o
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]             state_q, state_d;
  cmd_op_e                op_q, op_d;
  logic [FLOOR_W-1:0]     floor_q, floor_d;
  logic [CNT_W-1:0]       ptr_q, ptr_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [FLOOR_W-1:0]     head_q, head_d;
  logic [FLOOR_COUNT-1:0] up_q, up_d;
  logic [FLOOR_COUNT-1:0] dn_q, dn_d;
  logic [FLOOR_COUNT-1:0] cab_q, cab_d;
  logic                   drop_q, drop_d;
  logic                   out_valid_q, out_valid_d;
  eoq_result_t            out_q, out_d;

  logic [FLOOR_W-1:0]     slots_q [QUEUE_DEPTH];
  logic                   slot_we;
  logic [IDX_W-1:0]       slot_wa;
  logic [FLOOR_W-1:0]     slot_wd;

  logic [CNT_W-1:0]       nxt_ptr;
  logic [IDX_W-1:0]       rd_idx;
  logic [FLOOR_W-1:0]     rd_slot;
  logic [FLOOR_COUNT-1:0] floor_bit;
  logic                   scan_end, hit, full, shift_more, out_free;

  assign nxt_ptr    = ptr_q + CNT_W'(1);
  assign rd_idx     = (state_q == ST_SHIFT) ? nxt_ptr[IDX_W-1:0] : ptr_q[IDX_W-1:0];
  assign rd_slot    = slots_q[rd_idx];
  assign scan_end   = (ptr_q == count_q);
  assign hit        = (rd_slot == floor_q);
  assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign shift_more = (nxt_ptr < count_q);
  assign floor_bit  = FLOOR_COUNT'(1) << cmd_i.floor;
  assign out_free   = !out_valid_q || res_ready_i;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    floor_d     = floor_q;
    ptr_d       = ptr_q;
    count_d     = count_q;
    up_d        = up_q;
    dn_d        = dn_q;
    cab_d       = cab_q;
    drop_d      = drop_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_ready_i;
    slot_we     = 1'b0;
    slot_wa     = ptr_q[IDX_W-1:0];
    slot_wd     = rd_slot;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          op_d    = cmd_i.op;
          floor_d = cmd_i.floor;
          ptr_d   = '0;
          drop_d  = 1'b0;
          case (cmd_i.op)
            OP_PRESS: begin
              case (cmd_i.kind)
                KIND_UP:   up_d  = up_q | floor_bit;
                KIND_DOWN: dn_d  = dn_q | floor_bit;
                KIND_CAB:  cab_d = cab_q | floor_bit;
                default: ;
              endcase
              state_d = ST_SCAN;
            end
            OP_ARRIVE: begin
              up_d    = up_q & ~floor_bit;
              dn_d    = dn_q & ~floor_bit;
              cab_d   = cab_q & ~floor_bit;
              state_d = ST_SCAN;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          // floor not queued: append on press, or flag a full queue
          if (op_q == OP_PRESS) begin
            if (full) begin
              drop_d = 1'b1;
            end else begin
              slot_we = 1'b1;
              slot_wa = count_q[IDX_W-1:0];
              slot_wd = floor_q;
              count_d = count_q + CNT_W'(1);
            end
          end
          state_d = ST_DONE;
        end else if (hit) begin
          state_d = (op_q == OP_ARRIVE) ? ST_SHIFT : ST_DONE;
        end else begin
          ptr_d = nxt_ptr;
        end
      end
      ST_SHIFT: begin
        // pull later entries forward over the removed slot
        if (shift_more) begin
          slot_we = 1'b1;
          ptr_d   = nxt_ptr;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_d.next_floor     = (count_q != '0) ? head_q : '0;
          out_d.queue_nonempty = (count_q != '0);
          out_d.queue_length   = LEN_W'(count_q);
          out_d.up_requests    = VEC_W'(up_q);
          out_d.down_requests  = VEC_W'(dn_q);
          out_d.cab_requests   = VEC_W'(cab_q);
          out_d.dropped        = drop_q;
          out_valid_d          = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    head_d = (slot_we && slot_wa == '0) ? slot_wd : head_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_NONE;
      ptr_q       <= '0;
      count_q     <= '0;
      up_q        <= '0;
      dn_q        <= '0;
      cab_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      ptr_q       <= ptr_d;
      count_q     <= count_d;
      up_q        <= up_d;
      dn_q        <= dn_d;
      cab_q       <= cab_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    floor_q <= floor_d;
    head_q  <= head_d;
    out_q   <= out_d;
    if (slot_we) begin
      slots_q[slot_wa] <= slot_wd;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for elevator_order_queue: event words in, status words out.
// Depends on eoq_pkg and the elevator_order_queue RTL; a built-in floor-queue
// predictor supplies the expected status words.
`timescale 1ns / 100ps

module tb_top import eoq_pkg::*; ();

  localparam int unsigned FLOOR_COUNT = 4;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned LIMIT_CYCLES = 200000;
  // Back end holds an item while it walks the queue slots; the result is registered as it leaves
  localparam int unsigned SETTLE_CYCLES = QUEUE_DEPTH + 8;

  localparam logic FUNC_PRESS = ~FUNC_ARRIVE;
  // Button code with no meaning; a press carrying it must be ignored
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;   // [1:0] floor, rest zero
  logic [IN_TUSER_W-1:0]  s_axis_tuser_i;   // [0] func, [2:1] button_kind
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;   // [1:0] next_floor, [2] queue_nonempty,
                                            // [5:3] queue_length, [9:6] up_requests,
                                            // [13:10] down_requests,
                                            // [17:14] cab_requests, [18] dropped

  elevator_order_queue #(
    .FLOOR_COUNT(FLOOR_COUNT),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // Predicted block state
  logic [FLOOR_W-1:0] order_slots [QUEUE_DEPTH];
  int                 order_count;
  logic [VEC_W-1:0]   up_pend;
  logic [VEC_W-1:0]   down_pend;
  logic [VEC_W-1:0]   cab_pend;

  eoq_result_t status_q[$];   // expected status words, oldest first
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned ready_hold_left;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Applies one event to the predicted state and returns the status it leaves
  function automatic eoq_result_t apply_floor_event(input logic func,
                                                    input logic [FLOOR_W-1:0] fl,
                                                    input logic [KIND_W-1:0] kind);
    eoq_result_t res;
    logic        known;
    int          hit;
    res   = '0;
    known = 1'b1;
    hit   = -1;
    for (int i = 0; i < order_count; i++)
      if (hit < 0 && order_slots[i] == fl) hit = i;
    if (fl < FLOOR_COUNT) begin
      if (func == FUNC_ARRIVE) begin
        up_pend[fl]   = 1'b0;
        down_pend[fl] = 1'b0;
        cab_pend[fl]  = 1'b0;
        // Close the gap, the last slot included
        if (hit >= 0) begin
          for (int j = hit; j + 1 < order_count; j++) order_slots[j] = order_slots[j + 1];
          order_count--;
        end
      end else begin
        case (kind)
          KIND_UP:   up_pend[fl]   = 1'b1;
          KIND_DOWN: down_pend[fl] = 1'b1;
          KIND_CAB:  cab_pend[fl]  = 1'b1;
          default:   known = 1'b0;
        endcase
        if (known && hit < 0) begin
          if (order_count >= QUEUE_DEPTH) begin
            res.dropped = 1'b1;
          end else begin
            order_slots[order_count] = fl;
            order_count++;
          end
        end
      end
    end
    res.next_floor     = (order_count > 0) ? order_slots[0] : '0;
    res.queue_nonempty = (order_count > 0);
    res.queue_length   = LEN_W'(order_count);
    res.up_requests    = up_pend;
    res.down_requests  = down_pend;
    res.cab_requests   = cab_pend;
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Offers one event word; returns in the step of the accepting edge with tvalid
  // still high so that back-to-back words need no second assignment.
  task automatic send_event(input logic func, input logic [FLOOR_W-1:0] fl,
                            input logic [KIND_W-1:0] kind);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_TDATA_W'(fl);
    s_axis_tuser_i  <= {kind, func};
    do @(posedge clk_i); while (!s_axis_tready_o);
    status_q.push_back(apply_floor_event(func, fl, kind));
  endtask

  task automatic send_random_event(input int unsigned arrive_pct);
    logic               func;
    logic [FLOOR_W-1:0] fl;
    logic [KIND_W-1:0]  kind;
    func = ($urandom_range(99) < arrive_pct) ? FUNC_ARRIVE : FUNC_PRESS;
    fl   = FLOOR_W'($urandom_range(FLOOR_COUNT - 1));
    if (func == FUNC_ARRIVE)
      kind = KIND_W'($urandom_range(3));   // ignored, but toggles the bits
    else
      kind = ($urandom_range(99) < 8) ? KIND_UNUSED : KIND_W'($urandom_range(2));
    send_event(func, fl, kind);
  endtask

  // Drops tvalid and waits until every predicted word has come back
  task automatic wait_results_done();
    s_axis_tvalid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_events();
    // Fill with one button kind after another, all four floors
    send_event(FUNC_PRESS, 2'd2, KIND_UP);
    send_event(FUNC_PRESS, 2'd0, KIND_DOWN);
    send_event(FUNC_PRESS, 2'd3, KIND_CAB);
    send_event(FUNC_PRESS, 2'd1, KIND_UP);
    send_event(FUNC_PRESS, 2'd0, KIND_CAB);      // already queued
    send_event(FUNC_PRESS, 2'd1, KIND_UNUSED);   // meaningless button
    send_event(FUNC_PRESS, 2'd3, KIND_DOWN);
    send_event(FUNC_ARRIVE, 2'd1, KIND_UP);      // tail slot
    send_event(FUNC_ARRIVE, 2'd2, KIND_UNUSED);  // head slot
    send_event(FUNC_PRESS, 2'd2, KIND_DOWN);
    send_event(FUNC_ARRIVE, 2'd3, KIND_CAB);     // middle slot
    send_event(FUNC_PRESS, 2'd1, KIND_CAB);
    send_event(FUNC_ARRIVE, 2'd3, KIND_DOWN);    // floor not queued
    send_event(FUNC_PRESS, 2'd3, KIND_UP);
    send_event(FUNC_PRESS, 2'd2, KIND_UP);
    send_event(FUNC_ARRIVE, 2'd0, KIND_UP);
    send_event(FUNC_ARRIVE, 2'd2, KIND_UP);
    send_event(FUNC_ARRIVE, 2'd1, KIND_UP);
    send_event(FUNC_ARRIVE, 2'd3, KIND_UP);      // queue now empty
    send_event(FUNC_ARRIVE, 2'd0, KIND_UNUSED);  // arrival on empty queue
  endtask

  // Bursts with shifting press/arrival mix so the queue swings full and empty
  task automatic test_random_traffic(input int unsigned count);
    int unsigned arrive_pct;
    arrive_pct = 35;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) arrive_pct = 10 + 15 * $urandom_range(3);
      send_random_event(arrive_pct);
    end
  endtask

  // Receiver holds off while the sender keeps offering; input must stall
  task automatic test_output_backpressure();
    int unsigned saved_idle;
    saved_idle      = send_idle_pct;
    send_idle_pct   = 0;
    ready_hold_left = 120;
    for (int n = 0; n < 24; n++) send_random_event(30);
    send_idle_pct = saved_idle;
  endtask

  // Sender goes quiet until the block has answered everything
  task automatic test_drain_pause();
    for (int n = 0; n < 10; n++) send_random_event(30);
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    for (int n = 0; n < 10; n++) send_random_event(30);
  endtask

  initial begin
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= '0;
    order_count     = 0;
    up_pend         = '0;
    down_pend       = '0;
    cab_pend        = '0;
    mismatch_count  = 0;
    ready_hold_left = 0;
    send_idle_pct   = 18;
    recv_idle_pct   = 45;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_events();
    test_random_traffic(580);
    test_output_backpressure();

    send_idle_pct = 45;
    recv_idle_pct = 18;
    test_random_traffic(580);
    test_drain_pause();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(580);

    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && status_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Output side ready; a long hold-off is counted down here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (ready_hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      ready_hold_left--;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : status_check
    eoq_result_t got;
    eoq_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = eoq_result_t'(m_axis_tdata_o[$bits(eoq_result_t)-1:0]);
      if (status_q.size() == 0) begin
        $error("status word with none expected: %h", m_axis_tdata_o);
        mismatch_count++;
      end else begin
        want = status_q.pop_front();
        check_field("next_floor", want.next_floor, got.next_floor);
        check_field("queue_nonempty", want.queue_nonempty, got.queue_nonempty);
        check_field("queue_length", want.queue_length, got.queue_length);
        check_field("up_requests", want.up_requests, got.up_requests);
        check_field("down_requests", want.down_requests, got.down_requests);
        check_field("cab_requests", want.cab_requests, got.cab_requests);
        check_field("dropped", want.dropped, got.dropped);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
